>>> design/kars_pkg.sv
// Package for the keypad auto-repeat level setter.
// Holds register codes, reset values and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package kars_pkg;

  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned SCALE_W  = 4;
  localparam int unsigned DUTY_W   = 12;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam logic [LEVEL_W-1:0] FILTER_RELOAD_RST = 8'd255;
  localparam logic [LEVEL_W-1:0] REPEAT_RELOAD_RST = 8'd30;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST     = 8'd100;
  localparam logic [SCALE_W-1:0] DUTY_SCALE_RST    = 4'd10;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_FILTER_RELOAD = 2'd0,
    REG_REPEAT_RELOAD = 2'd1,
    REG_MAX_LEVEL     = 2'd2,
    REG_DUTY_SCALE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] heater_level;
    logic [LEVEL_W-1:0] fan_level;
    logic [DUTY_W-1:0]  heater_duty;
    logic [DUTY_W-1:0]  fan_duty;
    logic               heater_stepped;
    logic               fan_stepped;
  } result_t;

endpackage

>>> design/kars_if.sv
// Valid/ready channel interfaces for the keypad auto-repeat level setter.
// kars_in_if carries the button word, kars_out_if the result word.
// Depends on kars_pkg.
`timescale 1ns / 1ps

interface kars_in_if;
  logic valid;
  logic ready;
  logic heat_up_pressed;
  logic heat_down_pressed;
  logic fan_up_pressed;
  logic fan_down_pressed;

  modport source (
    output valid, heat_up_pressed, heat_down_pressed, fan_up_pressed, fan_down_pressed,
    input  ready
  );
  modport sink (
    input  valid, heat_up_pressed, heat_down_pressed, fan_up_pressed, fan_down_pressed,
    output ready
  );
endinterface

interface kars_out_if;
  logic                           valid;
  logic                           ready;
  logic [kars_pkg::LEVEL_W-1:0]   heater_level;
  logic [kars_pkg::LEVEL_W-1:0]   fan_level;
  logic [kars_pkg::DUTY_W-1:0]    heater_duty;
  logic [kars_pkg::DUTY_W-1:0]    fan_duty;
  logic                           heater_stepped;
  logic                           fan_stepped;

  modport source (
    output valid, heater_level, fan_level, heater_duty, fan_duty, heater_stepped, fan_stepped,
    input  ready
  );
  modport sink (
    input  valid, heater_level, fan_level, heater_duty, fan_duty, heater_stepped, fan_stepped,
    output ready
  );
endinterface

>>> design/keypad_auto_repeat_duty_setter_unit.sv
// Top level of the keypad auto-repeat level setter: counters, levels,
// duty products, APB register file and a two-deep output buffer.
// Depends on kars_pkg and kars_if.
//
//   channel   dir   word                                   handshake
//   in_ch     in    four button levels, one poll tick      valid/ready
//   out_ch    out   levels, duties, step flags             valid/ready
//   apb       in    filter/repeat reload, max, scale       psel/penable
//
// One tick per cycle while in_ch.ready is high; a taken tick's result is registered.
// The counter/level update, step and 8x4 duty product are combinational
// between the state registers and the result register.
// Reset (rst, synchronous) reloads registers and counters, empties buffer.
// A stalled sink fills the skid word; in_ch.ready drops only when it is full.
`timescale 1ns / 1ps

module keypad_auto_repeat_duty_setter_unit (
  input  logic                          clk,
  input  logic                          rst,
  kars_in_if.sink                       in_ch,
  kars_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kars_pkg::ADDR_W-1:0]   paddr,
  input  logic [kars_pkg::DATA_W-1:0]   pwdata,
  output logic [kars_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [kars_pkg::LEVEL_W-1:0] filter_reload;
  logic [kars_pkg::LEVEL_W-1:0] repeat_reload;
  logic [kars_pkg::LEVEL_W-1:0] max_level;
  logic [kars_pkg::SCALE_W-1:0] duty_scale;

  logic [kars_pkg::LEVEL_W-1:0] filter_count, filter_count_next;
  logic [kars_pkg::LEVEL_W-1:0] repeat_count, repeat_count_next;
  logic [kars_pkg::LEVEL_W-1:0] heater_value, heater_value_next;
  logic [kars_pkg::LEVEL_W-1:0] fan_value, fan_value_next;

  logic [kars_pkg::LEVEL_W-1:0] filter_dec, repeat_dec;
  logic                         any_held, step_fire, heat_ev, fan_ev;
  logic                         accept, pop, cfg_wr;
  kars_pkg::cfg_reg_t           cfg_sel;
  kars_pkg::result_t            res;

  logic              out_valid, skid_valid;
  kars_pkg::result_t out_data, skid_data;

  // ---------------- configuration registers ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = kars_pkg::cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_reload <= kars_pkg::FILTER_RELOAD_RST;
      repeat_reload <= kars_pkg::REPEAT_RELOAD_RST;
      max_level     <= kars_pkg::MAX_LEVEL_RST;
      duty_scale    <= kars_pkg::DUTY_SCALE_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        kars_pkg::REG_FILTER_RELOAD: filter_reload <= pwdata[7:0];
        kars_pkg::REG_REPEAT_RELOAD: repeat_reload <= pwdata[7:0];
        kars_pkg::REG_MAX_LEVEL:     max_level     <= pwdata[7:0];
        kars_pkg::REG_DUTY_SCALE:    duty_scale    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      kars_pkg::REG_FILTER_RELOAD: prdata = {24'd0, filter_reload};
      kars_pkg::REG_REPEAT_RELOAD: prdata = {24'd0, repeat_reload};
      kars_pkg::REG_MAX_LEVEL:     prdata = {24'd0, max_level};
      kars_pkg::REG_DUTY_SCALE:    prdata = {28'd0, duty_scale};
      default:                     prdata = '0;
    endcase
  end

  // ---------------- tick processing ----------------
  assign accept   = in_ch.valid && in_ch.ready;
  assign any_held = in_ch.heat_up_pressed || in_ch.heat_down_pressed ||
                    in_ch.fan_up_pressed  || in_ch.fan_down_pressed;
  assign filter_dec = filter_count - 8'd1;
  assign repeat_dec = repeat_count - 8'd1;
  // step only when both counters hit zero on this tick
  assign step_fire = any_held && (filter_dec == 8'd0) && (repeat_dec == 8'd0);
  assign heat_ev   = step_fire && (in_ch.heat_up_pressed || in_ch.heat_down_pressed);
  assign fan_ev    = step_fire && !heat_ev;

  always_comb begin
    filter_count_next = filter_count;
    repeat_count_next = repeat_count;
    heater_value_next = heater_value;
    fan_value_next    = fan_value;
    if (!any_held) begin
      filter_count_next = filter_reload;
    end else begin
      filter_count_next = filter_dec;
      if (filter_dec == 8'd0) begin
        repeat_count_next = step_fire ? repeat_reload : repeat_dec;
      end
    end
    if (heat_ev) begin
      if (in_ch.heat_up_pressed) begin
        if (heater_value < max_level) heater_value_next = heater_value + 8'd1;
      end else if (heater_value != 8'd0) begin
        heater_value_next = heater_value - 8'd1;
      end
    end
    if (fan_ev) begin
      if (in_ch.fan_up_pressed) begin
        if (fan_value < max_level) fan_value_next = fan_value + 8'd1;
      end else if (fan_value != 8'd0) begin
        fan_value_next = fan_value - 8'd1;
      end
    end
  end

  always_comb begin
    res.heater_level   = heater_value_next;
    res.fan_level      = fan_value_next;
    res.heater_duty    = 12'(heater_value_next) * 12'(duty_scale);
    res.fan_duty       = 12'(fan_value_next) * 12'(duty_scale);
    res.heater_stepped = heat_ev;
    res.fan_stepped    = fan_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_count <= kars_pkg::FILTER_RELOAD_RST;
      repeat_count <= kars_pkg::REPEAT_RELOAD_RST;
      heater_value <= '0;
      fan_value    <= '0;
    end else if (accept) begin
      filter_count <= filter_count_next;
      repeat_count <= repeat_count_next;
      heater_value <= heater_value_next;
      fan_value    <= fan_value_next;
    end
  end

  // ---------------- output register + skid word ----------------
  assign in_ch.ready = !skid_valid;
  assign pop         = out_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= res;
      end
    end else if (accept) begin
      skid_data <= res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.heater_level   = out_data.heater_level;
  assign out_ch.fan_level      = out_data.fan_level;
  assign out_ch.heater_duty    = out_data.heater_duty;
  assign out_ch.fan_duty       = out_data.fan_duty;
  assign out_ch.heater_stepped = out_data.heater_stepped;
  assign out_ch.fan_stepped    = out_data.fan_stepped;

endmodule

>>> design/kars_checker.sv
// Port-level checks for the keypad auto-repeat level setter, and the bind
// that attaches them to the top level.
// Depends on kars_pkg and keypad_auto_repeat_duty_setter_unit.
`timescale 1ns / 1ps

module kars_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kars_pkg::LEVEL_W-1:0]  heater_level,
  input logic [kars_pkg::LEVEL_W-1:0]  fan_level,
  input logic [kars_pkg::DUTY_W-1:0]   heater_duty,
  input logic [kars_pkg::DUTY_W-1:0]   fan_duty,
  input logic                          heater_stepped,
  input logic                          fan_stepped
);

  // a stalled word holds its valid, levels and step flags
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heater_level) && $stable(fan_level)
      && $stable(heater_stepped) && $stable(fan_stepped))
    else $error("stalled result word changed");

  // only one button acts per tick
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(heater_stepped && fan_stepped))
    else $error("both levels stepped on one tick");

  a_heat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && heater_level == 8'd0 |-> heater_duty == 12'd0)
    else $error("heater duty nonzero at level zero");

  a_fan_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fan_level == 8'd0 |-> fan_duty == 12'd0)
    else $error("fan duty nonzero at level zero");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind keypad_auto_repeat_duty_setter_unit kars_checker u_kars_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .heater_level   (out_ch.heater_level),
  .fan_level      (out_ch.fan_level),
  .heater_duty    (out_ch.heater_duty),
  .fan_duty       (out_ch.fan_duty),
  .heater_stepped (out_ch.heater_stepped),
  .fan_stepped    (out_ch.fan_stepped)
);
